// ----- sv/stftn_pkg.sv -----
// Shared widths, parameter defaults and the fixed-point sine/cosine used
// to build the window and twiddle tables. No dependencies.
package stftn_pkg;

  localparam int FRAME_SIZE_DEF    = 256;
  localparam int REPORTED_BINS_DEF = 64;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int WORK_W  = 32;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 64;
  localparam int NUM_W   = MAG_W + 8;
  localparam int FRAME_W = 16;
  localparam int BIN_W   = 6;
  localparam int LEVEL_W = 8;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] SC1     = 64'd1686629713;
  localparam logic [63:0] SC3     = 64'd693598668;
  localparam logic [63:0] SC5     = 64'd85569306;
  localparam logic [63:0] SC7     = 64'd5026996;
  localparam logic [63:0] SC9     = 64'd172268;

  function automatic logic [15:0] sin_quarter(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] r;
    t2 = (t * t) >> 30;
    p  = SC9;
    p  = SC7 - ((t2 * p) >> 30);
    p  = SC5 - ((t2 * p) >> 30);
    p  = SC3 - ((t2 * p) >> 30);
    p  = SC1 - ((t2 * p) >> 30);
    r  = (((t * p) >> 30) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] cos_turn(logic [31:0] ph);
    logic [63:0] r;
    logic signed [15:0] v;
    r = {34'd0, ph[29:0]};
    unique case (ph[31:30])
      2'd0: v = $signed(sin_quarter(Q30_ONE - r));
      2'd1: v = -$signed(sin_quarter(r));
      2'd2: v = -$signed(sin_quarter(Q30_ONE - r));
      default: v = $signed(sin_quarter(r));
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sin_turn(logic [31:0] ph);
    logic [63:0] r;
    logic signed [15:0] v;
    r = {34'd0, ph[29:0]};
    unique case (ph[31:30])
      2'd0: v = $signed(sin_quarter(r));
      2'd1: v = $signed(sin_quarter(Q30_ONE - r));
      2'd2: v = -$signed(sin_quarter(r));
      default: v = -$signed(sin_quarter(Q30_ONE - r));
    endcase
    return v;
  endfunction

endpackage

// ----- sv/stft_magnitude_normaliser.sv -----
// Short-time magnitude spectrum with Hann window and 8-bit normalized levels.
// Depends on stftn_pkg, stftn_isqrt and stftn_level_div.
//
// Input channel (in_valid/in_ready): one signed sample per request, with
// first_of_signal restarting framing and frame numbering at that sample.
// Output channel (out_valid/out_ready): REPORTED_BINS requests per frame,
// each carrying frame_number, bin_number, level and last_bin on the final bin.
// A sample that does not complete a frame is taken while the block stays
// idle. The sample that fills a frame (then every FRAME_SIZE/2 samples)
// starts the frame work, and in_ready stays low until the last level of that
// frame sits in the output register: windowing of the frame (read, multiply,
// write per sample), (FRAME_SIZE/2)*log2(FRAME_SIZE) butterflies through the
// shared work memory, a square root and a divide per reported bin, plus any
// time the receiver holds out_ready low. A stalled receiver holds the result
// register and the sequencer waits before loading the next bin.
// Reset clears framing, frame numbering and out_valid; the memories
// need no clearing.
module stft_magnitude_normaliser #(
  parameter int FRAME_SIZE    = stftn_pkg::FRAME_SIZE_DEF,
  parameter int REPORTED_BINS = stftn_pkg::REPORTED_BINS_DEF,
  parameter int SAMPLE_BITS   = stftn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             sample,
  input  logic                           first_of_signal,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stftn_pkg::FRAME_W-1:0]   frame_number,
  output logic [stftn_pkg::BIN_W-1:0]     bin_number,
  output logic [stftn_pkg::LEVEL_W-1:0]   level,
  output logic                           last_bin
);
  import stftn_pkg::*;

  localparam int AW   = $clog2(FRAME_SIZE);
  localparam int LOGN = AW;
  localparam int SW   = $clog2(LOGN);
  localparam int BW   = (REPORTED_BINS > 1) ? $clog2(REPORTED_BINS) : 1;
  localparam int PW   = SAMPLE_BITS + 17;
  localparam logic [AW:0]   FULL      = (AW + 1)'(FRAME_SIZE);
  localparam logic [AW:0]   HALF_FULL = (AW + 1)'(FRAME_SIZE / 2);
  localparam logic [AW-1:0] MID       = AW'(FRAME_SIZE / 2);
  localparam logic [SW-1:0] LAST_ST   = SW'(LOGN - 1);
  localparam logic [BW-1:0] LAST_B    = BW'(REPORTED_BINS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD_RD, S_LOAD_MUL, S_LOAD_WR,
    S_BF_RD, S_BF_MUL, S_BF_SUM, S_BF_WA, S_BF_WB,
    S_MAG_RD, S_MAG_MUL, S_MAG_GO, S_MAG_WAIT, S_MAX_FIX,
    S_OUT_RD, S_OUT_GO, S_OUT_WAIT, S_OUT_EMIT
  } state_t;

  function automatic logic [15:0] hann_entry(int n);
    logic [63:0] ph;
    int d;
    ph = (64'(n) << 32) / 64'(FRAME_SIZE - 1);
    d  = 32768 - int'(cos_turn(ph[31:0]));
    return 16'(d >>> 1);
  endfunction

  function automatic logic [31:0] tw_phase(int n);
    logic [63:0] ph;
    ph = 64'(n) << (32 - LOGN);
    return ph[31:0];
  endfunction

  logic [15:0]        hann_rom [FRAME_SIZE];
  logic signed [15:0] tw_cos   [FRAME_SIZE/2];
  logic signed [15:0] tw_sin   [FRAME_SIZE/2];

  for (genvar n = 0; n < FRAME_SIZE; n++) begin : g_hann
    assign hann_rom[n] = hann_entry(n);
  end
  for (genvar n = 0; n < FRAME_SIZE / 2; n++) begin : g_tw
    assign tw_cos[n] = cos_turn(tw_phase(n));
    assign tw_sin[n] = sin_turn(tw_phase(n));
  end

  state_t state;
  logic [AW-1:0]      wp;
  logic [AW:0]        seen;
  logic [AW:0]        seen_inc;
  logic [FRAME_W-1:0] frame_count;
  logic [AW-1:0]      cnt;
  logic [AW-2:0]      k;
  logic [SW-1:0]      stage;
  logic [BW-1:0]      b;
  logic [MAG_W-1:0]   mx;

  logic signed [SAMPLE_BITS-1:0] x_in;
  if (SAMPLE_BITS <= 16) begin : g_narrow
    assign x_in = sample[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign x_in = {{(SAMPLE_BITS - 16){1'b0}}, sample};
  end

  logic signed [SAMPLE_BITS-1:0] hist_mem [FRAME_SIZE];
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic [AW-1:0]                 hist_raddr;
  logic [2*WORK_W-1:0]           work_mem [FRAME_SIZE];
  logic [2*WORK_W-1:0]           rd_a;
  logic [2*WORK_W-1:0]           rd_b;
  logic [MAG_W-1:0]              mag_mem  [REPORTED_BINS];
  logic [MAG_W-1:0]              mag_q;

  logic [AW-1:0]       rev;
  logic [AW-2:0]       lowmask;
  logic [AW-2:0]       low;
  logic [AW-2:0]       tk;
  logic [SW-1:0]       shamt;
  logic [AW-1:0]       ia;
  logic [AW-1:0]       ib;
  logic [AW-1:0]       ra_addr;
  logic [AW-1:0]       rb_addr;
  logic                work_we;
  logic [AW-1:0]       work_waddr;
  logic [2*WORK_W-1:0] work_wdata;

  logic [15:0]               hann_q;
  logic signed [15:0]        tw_c_q;
  logic signed [15:0]        tw_s_q;
  logic signed [PW-1:0]      wprod;
  logic signed [47:0]        p1, p2, p3, p4;
  logic signed [48:0]        s_r, s_i;
  logic signed [WORK_W-1:0]  ar_q, ai_q;
  logic signed [33:0]        tr, ti;
  logic signed [34:0]        sum_r, sum_i, dif_r, dif_i;
  logic signed [WORK_W-1:0]  win;
  logic signed [WORK_W-1:0]  m_re, m_im;
  logic signed [SQ_W-1:0]    sq1, sq2;

  logic             sq_start, sq_done;
  logic [MAG_W-1:0] sq_root;
  logic             dv_start, dv_done;
  logic [NUM_W-1:0] dv_num;
  logic [LEVEL_W-1:0] dv_level;

  assign in_ready   = (state == S_IDLE);
  assign seen_inc   = (first_of_signal ? '0 : seen) + 1'b1;
  assign hist_raddr = wp + cnt;

  always_comb begin
    for (int i = 0; i < AW; i++) rev[i] = cnt[AW-1-i];
  end

  assign lowmask = (AW - 1)'((1 << stage) - 1);
  assign low     = k & lowmask;
  assign ia      = {k & ~lowmask, 1'b0} | {1'b0, low};
  assign ib      = ia | (AW'(1) << stage);
  assign shamt   = LAST_ST - stage;
  assign tk      = low << shamt;

  always_comb begin
    unique case (state)
      S_MAG_RD, S_MAG_MUL: begin
        ra_addr = AW'(b);
        rb_addr = MID;
      end
      default: begin
        ra_addr = ia;
        rb_addr = ib;
      end
    endcase
  end

  assign win   = WORK_W'($signed(wprod[PW-1:15]));
  assign s_r   = p1 + p2;
  assign s_i   = p3 - p4;
  assign sum_r = ar_q + tr;
  assign sum_i = ai_q + ti;
  assign dif_r = ar_q - tr;
  assign dif_i = ai_q - ti;

  always_comb begin
    work_we    = 1'b0;
    work_waddr = ia;
    work_wdata = {sum_i[32:1], sum_r[32:1]};
    unique case (state)
      S_LOAD_WR: begin
        work_we    = 1'b1;
        work_waddr = rev;
        work_wdata = {{WORK_W{1'b0}}, win};
      end
      S_BF_WA: work_we = 1'b1;
      S_BF_WB: begin
        work_we    = 1'b1;
        work_waddr = ib;
        work_wdata = {dif_i[32:1], dif_r[32:1]};
      end
      default: work_we = 1'b0;
    endcase
  end

  assign m_re     = $signed(rd_a[WORK_W-1:0]);
  assign m_im     = (b == '0) ? $signed(rd_b[WORK_W-1:0]) : $signed(rd_a[2*WORK_W-1:WORK_W]);
  assign sq_start = (state == S_MAG_GO);
  assign dv_start = (state == S_OUT_GO);
  assign dv_num   = {mag_q, 8'd0} - NUM_W'(mag_q);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) hist_mem[wp] <= x_in;
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_waddr] <= work_wdata;
    rd_a <= work_mem[ra_addr];
    rd_b <= work_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_MAG_WAIT && sq_done) mag_mem[b] <= sq_root;
    mag_q <= mag_mem[b];
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD_RD) hann_q <= hann_rom[cnt];
    if (state == S_LOAD_MUL) wprod <= hist_q * $signed({1'b0, hann_q});
    if (state == S_BF_RD) begin
      tw_c_q <= tw_cos[tk];
      tw_s_q <= tw_sin[tk];
    end
    if (state == S_BF_MUL) begin
      p1   <= $signed(rd_b[WORK_W-1:0]) * tw_c_q;
      p2   <= $signed(rd_b[2*WORK_W-1:WORK_W]) * tw_s_q;
      p3   <= $signed(rd_b[2*WORK_W-1:WORK_W]) * tw_c_q;
      p4   <= $signed(rd_b[WORK_W-1:0]) * tw_s_q;
      ar_q <= $signed(rd_a[WORK_W-1:0]);
      ai_q <= $signed(rd_a[2*WORK_W-1:WORK_W]);
    end
    if (state == S_BF_SUM) begin
      tr <= s_r[48:15];
      ti <= s_i[48:15];
    end
    if (state == S_MAG_MUL) begin
      sq1 <= m_re * m_re;
      sq2 <= m_im * m_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wp          <= '0;
      seen        <= '0;
      frame_count <= '0;
      out_valid   <= 1'b0;
      cnt         <= '0;
      k           <= '0;
      stage       <= '0;
      b           <= '0;
      mx          <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            wp <= wp + 1'b1;
            if (first_of_signal) frame_count <= '0;
            if (seen_inc == FULL) begin
              seen  <= HALF_FULL;
              cnt   <= '0;
              state <= S_LOAD_RD;
            end else begin
              seen <= seen_inc;
            end
          end
        end
        S_LOAD_RD:  state <= S_LOAD_MUL;
        S_LOAD_MUL: state <= S_LOAD_WR;
        S_LOAD_WR: begin
          cnt <= cnt + 1'b1;
          if (&cnt) begin
            k     <= '0;
            stage <= '0;
            state <= S_BF_RD;
          end else begin
            state <= S_LOAD_RD;
          end
        end
        S_BF_RD:  state <= S_BF_MUL;
        S_BF_MUL: state <= S_BF_SUM;
        S_BF_SUM: state <= S_BF_WA;
        S_BF_WA:  state <= S_BF_WB;
        S_BF_WB: begin
          k <= k + 1'b1;
          if (&k && stage == LAST_ST) begin
            b     <= '0;
            mx    <= '0;
            state <= S_MAG_RD;
          end else begin
            if (&k) stage <= stage + 1'b1;
            state <= S_BF_RD;
          end
        end
        S_MAG_RD:  state <= S_MAG_MUL;
        S_MAG_MUL: state <= S_MAG_GO;
        S_MAG_GO:  state <= S_MAG_WAIT;
        S_MAG_WAIT: begin
          if (sq_done) begin
            if (sq_root > mx) mx <= sq_root;
            if (b == LAST_B) begin
              b     <= '0;
              state <= S_MAX_FIX;
            end else begin
              b     <= b + 1'b1;
              state <= S_MAG_RD;
            end
          end
        end
        S_MAX_FIX: begin
          if (mx == '0) mx <= MAG_W'(1);
          state <= S_OUT_RD;
        end
        S_OUT_RD: state <= S_OUT_GO;
        S_OUT_GO: state <= S_OUT_WAIT;
        S_OUT_WAIT: begin
          if (dv_done) state <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            frame_number <= frame_count;
            bin_number   <= BIN_W'(b);
            level        <= dv_level;
            last_bin     <= (b == LAST_B);
            if (b == LAST_B) begin
              frame_count <= frame_count + 1'b1;
              state       <= S_IDLE;
            end else begin
              b     <= b + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  stftn_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq1 + sq2),
    .done     (sq_done),
    .root     (sq_root)
  );

  stftn_level_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (mx),
    .done  (dv_done),
    .level (dv_level)
  );

  a_last_bin_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_bin |-> bin_number == BIN_W'(REPORTED_BINS - 1))
    else $error("last_bin flagged on wrong bin");

  a_seen_below_frame: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> seen < FULL)
    else $error("sample count reached a full frame while idle");

  a_max_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT_RD |-> mx != '0)
    else $error("zero normalization maximum");

  a_sqrt_done_expected: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_MAG_WAIT)
    else $error("square root finished outside magnitude phase");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> state == S_OUT_WAIT)
    else $error("divide finished outside output phase");

endmodule

// ----- sv/stftn_isqrt.sv -----
// Bit-pair iterative integer square root, one step per cycle.
// Depends on stftn_pkg for the radicand and root widths.
module stftn_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [stftn_pkg::SQ_W-1:0]  radicand,
  output logic                       done,
  output logic [stftn_pkg::MAG_W-1:0] root
);
  import stftn_pkg::*;

  logic            busy;
  logic [SQ_W-1:0] v;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitp;
  logic [SQ_W-1:0] trial;

  assign trial = res + bitp;
  assign root  = res[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= radicand;
        res  <= '0;
        bitp <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitp;
        end else begin
          res <= res >> 1;
        end
        bitp <= bitp >> 2;
        if (bitp == SQ_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/stftn_level_div.sv -----
// Restoring divider for the 8-bit level, one quotient bit per cycle.
// Depends on stftn_pkg for the numerator and divisor widths.
module stftn_level_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [stftn_pkg::NUM_W-1:0]   num,
  input  logic [stftn_pkg::MAG_W-1:0]   den,
  output logic                         done,
  output logic [stftn_pkg::LEVEL_W-1:0] level
);
  import stftn_pkg::*;

  localparam int QW = LEVEL_W + 1;

  logic             busy;
  logic [3:0]       step;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] den_sh;
  logic [QW-1:0]    quo;

  assign level = quo[QW-1] ? '1 : quo[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        step   <= '0;
        rem    <= num;
        den_sh <= {den, 8'd0};
        quo    <= '0;
      end else if (busy) begin
        if (rem >= den_sh) begin
          rem <= rem - den_sh;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        den_sh <= den_sh >> 1;
        step   <= step + 1'b1;
        if (step == 4'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
